FILE: sv/deq_pkg.sv
// Shared constants, operation and status codes, and control types for the deque.
package deq_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 9;
  localparam int DATA_W  = 32;

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd_done;
  } deq_cmd_t;

  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } deq_stat_t;

endpackage

FILE: sv/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/deq_ctrl.sv
// Controller state machine that sequences request acceptance and store reads.
module deq_ctrl import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready    = (state_r == S_IDLE) && stat.out_free;
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.rd_done = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.pop_ok) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/deq_dp.sv
// Datapath holding the pointers, the entry count, the entry store and the result register.
module deq_dp import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  deq_cmd_t                 cmd,
  output deq_stat_t                stat,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [1:0]               out_status,
  output logic [COUNT_W-1:0]       out_count
);

  logic [ADDR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [ADDR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               full, empty, is_pop, push_ok, pop_ok;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  assign full    = count_r >= CNT_W'(DEPTH);
  assign empty   = (count_r == '0);
  assign is_pop  = in_kind[1];
  assign push_ok = !is_pop && !full;
  assign pop_ok  = is_pop && !empty;

  assign head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == ADDR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? ADDR_W'(DEPTH - 1) : tail_r - 1'b1;

  assign ram_we    = cmd.accept && push_ok;
  assign ram_re    = cmd.accept && pop_ok;
  assign ram_waddr = (in_kind == KIND_PUSH_FRONT) ? head_dec : tail_r;
  assign ram_raddr = (in_kind == KIND_POP_FRONT) ? head_r : tail_dec;

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.accept && (push_ok || pop_ok)) begin
      case (in_kind)
        KIND_PUSH_FRONT: begin
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
        KIND_PUSH_BACK: begin
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
        end
        KIND_POP_FRONT: begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
        default: begin
          tail_nxt  = tail_dec;
          count_nxt = count_r - 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (cmd.accept && !pop_ok) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_status_nxt = is_pop ? ST_EMPTY : (full ? ST_FULL : ST_OK);
      out_count_nxt  = COUNT_W'(count_nxt);
    end else if (cmd.rd_done) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = ram_rdata;
      out_status_nxt = ST_OK;
      out_count_nxt  = COUNT_W'(count_r);
    end else if (out_ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign stat.pop_ok   = pop_ok;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_popped_value = $signed(out_value_r);
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;

endmodule

FILE: sv/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit values.
//
// Requests arrive on the in_ channel (valid/ready) and carry an operation code
// in in_kind (push front, push back, pop front, pop back) and a value that
// only pushes use. Every request yields exactly one response on the out_
// channel with the popped value, a status code and the entry count afterward.
// A push to a full queue is dropped and answered with the full status; a pop
// from an empty queue is answered with the empty status; both leave the queue
// unchanged and return a zero value.
// A push or a refused request is answered in the cycle after acceptance. A
// successful pop goes through the store's registered read port and then the
// output register. The block handles one request at a time: it sustains one
// push per cycle while out_ready stays high, but takes none while a pop reads.
// Reset clears the pointers and the count, which empties the queue at once;
// the entry store itself is not cleared. While the receiver holds out_ready
// low, the response stays in the output register and no new request is
// taken until that register frees up.
module double_ended_queue import deq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [1:0]               out_status,
  output logic [COUNT_W-1:0]       out_count
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  deq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_popped_value(out_popped_value),
    .out_status      (out_status),
    .out_count       (out_count)
  );

endmodule
